>>> src/mcc_pkg.sv
package mcc_pkg;

   localparam int DEF_MAX_AMOUNT = 1023;
   localparam int DEF_MAX_COINS  = 6;

   localparam int NUM_COIN_REGS = 6;
   localparam int COIN_W        = 10;
   localparam int CNT_W         = 11;
   localparam int OUT_W         = 10;
   localparam int IDX_W         = 3;
   localparam int CSR_W         = 10;

   // all-ones count marks an amount that cannot be formed
   localparam logic [CNT_W-1:0] UNREACH = '1;

   typedef logic [NUM_COIN_REGS-1:0][COIN_W-1:0] coin_arr_type;
   typedef logic [NUM_COIN_REGS-1:0][OUT_W-1:0]  tally_arr_type;

   localparam coin_arr_type     COIN_RESET      = {10'd1, 10'd1, 10'd1, 10'd3, 10'd2, 10'd1};
   localparam logic [IDX_W-1:0] NUM_COINS_RESET = 3'd3;

   typedef enum logic [IDX_W-1:0] {
      CSR_NUM_COINS = 3'd0,
      CSR_COIN_A    = 3'd1,
      CSR_COIN_B    = 3'd2,
      CSR_COIN_C    = 3'd3,
      CSR_COIN_D    = 3'd4,
      CSR_COIN_E    = 3'd5,
      CSR_COIN_F    = 3'd6
   } csr_idx_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT,
      OP_ISSUE,
      OP_FILL_COMMIT,
      OP_CHECK_RD,
      OP_CHECK_EVAL,
      OP_TB_COMMIT
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] coin_sel;
   } cmd_type;

   typedef struct packed {
      logic tgt_over;
      logic tgt_zero;
      logic amt_at_target;
      logic chk_unreach;
      logic rem_zero;
   } stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_FILL_ISSUE,
      ST_FILL_COMMIT,
      ST_CHECK_RD,
      ST_CHECK_EVAL,
      ST_TB_ISSUE,
      ST_TB_COMMIT,
      ST_DONE
   } state_type;

endpackage

>>> src/mcc_csr.sv
module mcc_csr
   import mcc_pkg::*;
#(
   parameter int MAX_COINS = DEF_MAX_COINS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]   csr_wdata,
   output logic [IDX_W-1:0]   n_act,
   output coin_arr_type       coins
);

   logic [IDX_W-1:0] num_coins_ff;
   coin_arr_type     coin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_coins_ff <= NUM_COINS_RESET;
         coin_ff      <= COIN_RESET;
      end else if (csr_we) begin
         priority if (csr_index == CSR_NUM_COINS) begin
            num_coins_ff <= csr_wdata[IDX_W-1:0];
         end else if (csr_index >= CSR_COIN_A && csr_index <= CSR_COIN_F) begin
            coin_ff[csr_index - CSR_COIN_A] <= csr_wdata[COIN_W-1:0];
         end else begin
            // unknown index, write dropped
         end
      end
   end

   // saturate the active count
   assign n_act = (num_coins_ff > IDX_W'(MAX_COINS)) ? IDX_W'(MAX_COINS) : num_coins_ff;
   assign coins = coin_ff;

endmodule

>>> src/mcc_ctrl.sv
module mcc_ctrl
   import mcc_pkg::*;
#(
   parameter int MAX_COINS = DEF_MAX_COINS
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_valid
);

   localparam logic [IDX_W-1:0] LAST_COIN = IDX_W'(MAX_COINS - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] coin_ff, coin_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         coin_ff  <= '0;
      end else begin
         state_ff <= state_in;
         coin_ff  <= coin_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      coin_in      = coin_ff;
      cmd.op       = OP_NONE;
      cmd.coin_sel = coin_ff;
      unique case (state_ff)
         ST_IDLE: begin
            coin_in = '0;
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.op = OP_INIT;
            priority if (stat.tgt_over) state_in = ST_DONE;
            else if (stat.tgt_zero)     state_in = ST_CHECK_RD;
            else                        state_in = ST_FILL_ISSUE;
         end
         ST_FILL_ISSUE: begin
            cmd.op = OP_ISSUE;
            if (coin_ff == LAST_COIN) begin
               coin_in  = '0;
               state_in = ST_FILL_COMMIT;
            end else begin
               coin_in = coin_ff + 1'b1;
            end
         end
         ST_FILL_COMMIT: begin
            cmd.op   = OP_FILL_COMMIT;
            state_in = stat.amt_at_target ? ST_CHECK_RD : ST_FILL_ISSUE;
         end
         ST_CHECK_RD: begin
            cmd.op   = OP_CHECK_RD;
            state_in = ST_CHECK_EVAL;
         end
         ST_CHECK_EVAL: begin
            cmd.op   = OP_CHECK_EVAL;
            state_in = (stat.chk_unreach || stat.tgt_zero) ? ST_DONE : ST_TB_ISSUE;
         end
         ST_TB_ISSUE: begin
            cmd.op = OP_ISSUE;
            if (coin_ff == LAST_COIN) begin
               coin_in  = '0;
               state_in = ST_TB_COMMIT;
            end else begin
               coin_in = coin_ff + 1'b1;
            end
         end
         ST_TB_COMMIT: begin
            cmd.op   = OP_TB_COMMIT;
            state_in = stat.rem_zero ? ST_DONE : ST_TB_ISSUE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

>>> src/mcc_dpath.sv
module mcc_dpath
   import mcc_pkg::*;
#(
   parameter int MAX_AMOUNT = DEF_MAX_AMOUNT
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [OUT_W-1:0]   target_amount,
   input  logic [IDX_W-1:0]   n_act,
   input  coin_arr_type       coins,
   output stat_type           stat,
   output logic [OUT_W-1:0]   min_count,
   output logic               reachable,
   output tally_arr_type      tally
);

   localparam int DEPTH = MAX_AMOUNT + 1;
   localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int SW    = (AW > COIN_W) ? AW : COIN_W;

   logic [CNT_W-1:0] mem [DEPTH];

   logic [AW-1:0]     tgt_ff, amt_ff;
   logic              tgt_over_ff;
   logic              rd_valid_ff;
   logic [IDX_W-1:0]  rd_idx_ff, pick_ff;
   logic [COIN_W-1:0] rd_coin_ff, best_coin_ff;
   logic [CNT_W-1:0]  rdata_ff, best_ff;
   logic [OUT_W-1:0]  min_count_ff;
   logic              reachable_ff;
   tally_arr_type     tally_ff;

   logic [COIN_W-1:0] coin_cur, coin_nx;
   logic              fits, take;
   logic [SW-1:0]     issue_diff, rem_diff;
   logic [AW-1:0]     raddr;
   logic [CNT_W-1:0]  best_nx, fill_val;
   logic [IDX_W-1:0]  pick_nx;
   logic              mem_we;
   logic [AW-1:0]     waddr;
   logic [CNT_W-1:0]  wdata;

   // coin under test and its remainder address
   assign coin_cur   = (cmd.coin_sel < IDX_W'(NUM_COIN_REGS)) ? coins[cmd.coin_sel] : '0;
   assign fits       = (cmd.coin_sel < n_act) && (coin_cur != '0)
                       && (SW'(coin_cur) <= SW'(amt_ff));
   assign issue_diff = SW'(amt_ff) - SW'(coin_cur);
   assign raddr      = (cmd.op == OP_CHECK_RD) ? tgt_ff : issue_diff[AW-1:0];

   // running minimum, strict so ties keep the lower coin index
   assign take     = rd_valid_ff && (rdata_ff < best_ff);
   assign best_nx  = take ? rdata_ff   : best_ff;
   assign pick_nx  = take ? rd_idx_ff  : pick_ff;
   assign coin_nx  = take ? rd_coin_ff : best_coin_ff;
   assign fill_val = (best_nx == UNREACH) ? UNREACH : best_nx + CNT_W'(1);
   assign rem_diff = SW'(amt_ff) - SW'(coin_nx);

   assign mem_we = (cmd.op == OP_INIT) || (cmd.op == OP_FILL_COMMIT);
   assign waddr  = (cmd.op == OP_INIT) ? '0 : amt_ff;
   assign wdata  = (cmd.op == OP_INIT) ? '0 : fill_val;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= (cmd.op == OP_ISSUE) && fits;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= cmd.coin_sel;
      rd_coin_ff <= coin_cur;
      unique case (cmd.op)
         OP_LOAD: begin
            tgt_ff       <= AW'(target_amount);
            tgt_over_ff  <= (int'(target_amount) > MAX_AMOUNT);
            best_ff      <= UNREACH;
            min_count_ff <= '0;
            reachable_ff <= 1'b0;
            tally_ff     <= '0;
         end
         OP_INIT: begin
            amt_ff <= AW'(1);
         end
         OP_ISSUE: begin
            best_ff      <= best_nx;
            pick_ff      <= pick_nx;
            best_coin_ff <= coin_nx;
         end
         OP_FILL_COMMIT: begin
            best_ff <= UNREACH;
            amt_ff  <= amt_ff + AW'(1);
         end
         OP_CHECK_EVAL: begin
            amt_ff <= tgt_ff;
            if (rdata_ff != UNREACH) begin
               min_count_ff <= rdata_ff[OUT_W-1:0];
               reachable_ff <= 1'b1;
            end
         end
         OP_TB_COMMIT: begin
            best_ff <= UNREACH;
            amt_ff  <= rem_diff[AW-1:0];
            for (int i = 0; i < NUM_COIN_REGS; i++) begin
               if (pick_nx == IDX_W'(i)) begin
                  tally_ff[i] <= tally_ff[i] + OUT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign stat.tgt_over      = tgt_over_ff;
   assign stat.tgt_zero      = (tgt_ff == '0);
   assign stat.amt_at_target = (amt_ff == tgt_ff);
   assign stat.chk_unreach   = (rdata_ff == UNREACH);
   assign stat.rem_zero      = (SW'(amt_ff) == SW'(coin_nx));

   assign min_count = min_count_ff;
   assign reachable = reachable_ff;
   assign tally     = tally_ff;

endmodule

>>> src/min_coin_change_dp.sv
// sequence: load, init, fill sweep over every amount up to the target, table check,
//    traceback one coin at a time (skipped when unreachable), then the result strobe
// throughput: one transaction at a time, next start taken the cycle after the strobe
// the count table's single read port sets the pace: one remainder read per coin per amount
// reset clears the controller and loads the default coin set; the table needs no clearing
// the receiver cannot stall: rsp_valid is high for exactly one cycle
module min_coin_change_dp
   import mcc_pkg::*;
#(
   parameter int MAX_AMOUNT = DEF_MAX_AMOUNT,
   parameter int MAX_COINS  = DEF_MAX_COINS
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  logic [OUT_W-1:0]   req_target_amount,
   // response channel
   output logic               rsp_valid,
   output logic [OUT_W-1:0]   rsp_min_count,
   output logic               rsp_reachable,
   output logic [OUT_W-1:0]   rsp_tally_a,
   output logic [OUT_W-1:0]   rsp_tally_b,
   output logic [OUT_W-1:0]   rsp_tally_c,
   output logic [OUT_W-1:0]   rsp_tally_d,
   output logic [OUT_W-1:0]   rsp_tally_e,
   output logic [OUT_W-1:0]   rsp_tally_f,
   // register write port
   input  logic               csr_we,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   cmd_type          cmd;
   stat_type         stat;
   logic [IDX_W-1:0] n_act;
   coin_arr_type     coins;
   tally_arr_type    tally;

   // coin set and active count
   mcc_csr #(
      .MAX_COINS (MAX_COINS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .n_act     (n_act),
      .coins     (coins)
   );

   // sequencer: fill sweep, table check, traceback, result strobe
   mcc_ctrl #(
      .MAX_COINS (MAX_COINS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // count table, running minimum and tallies
   mcc_dpath #(
      .MAX_AMOUNT (MAX_AMOUNT)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .target_amount (req_target_amount),
      .n_act         (n_act),
      .coins         (coins),
      .stat          (stat),
      .min_count     (rsp_min_count),
      .reachable     (rsp_reachable),
      .tally         (tally)
   );

   // result fields straight from the datapath registers
   assign rsp_tally_a = tally[0];
   assign rsp_tally_b = tally[1];
   assign rsp_tally_c = tally[2];
   assign rsp_tally_d = tally[3];
   assign rsp_tally_e = tally[4];
   assign rsp_tally_f = tally[5];

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after accepting a transaction");

   // a result only ends a transaction in flight
   a_rsp_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // the strobe is a single cycle and the block goes idle after it
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

   // an unreachable amount reports zero count and zero tallies
   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_reachable) |->
         (rsp_min_count == '0 && rsp_tally_a == '0 && rsp_tally_b == '0
          && rsp_tally_c == '0 && rsp_tally_d == '0 && rsp_tally_e == '0
          && rsp_tally_f == '0))
      else $error("unreachable result with nonzero fields");

endmodule

>>> test/min_coin_change_dp_test.sv
`timescale 1ns / 1ps

module min_coin_change_dp_test;
   import mcc_pkg::*;

   // write to an index past the last register, which the block must ignore
   localparam logic [IDX_W-1:0] CSR_IDX_UNUSED = 3'd7;
   // cycle limit for the whole run, above every transaction at its longest
   localparam int CYCLE_LIMIT = 8_000_000;
   // longest transaction: coin of 1 and target 1023, plus margin
   localparam int SETTLE_CYCLES = 15_000;

   // expected outcome of one transaction
   typedef struct {
      logic [OUT_W-1:0] min_count;
      logic             reachable;
      tally_arr_type    tally;
   } change_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [OUT_W-1:0]   req_target_amount = '0;
   logic               rsp_valid;
   logic [OUT_W-1:0]   rsp_min_count;
   logic               rsp_reachable;
   logic [OUT_W-1:0]   rsp_tally_a;
   logic [OUT_W-1:0]   rsp_tally_b;
   logic [OUT_W-1:0]   rsp_tally_c;
   logic [OUT_W-1:0]   rsp_tally_d;
   logic [OUT_W-1:0]   rsp_tally_e;
   logic [OUT_W-1:0]   rsp_tally_f;
   logic               csr_we = 1'b0;
   logic [IDX_W-1:0]   csr_index = '0;
   logic [CSR_W-1:0]   csr_wdata = '0;

   // shadow copy of the coin set and the count table of the predictor
   coin_arr_type       coin_value = COIN_RESET;
   logic [IDX_W-1:0]   coin_count = NUM_COINS_RESET;
   logic [CNT_W-1:0]   dp_counts [0:DEF_MAX_AMOUNT];

   logic [OUT_W-1:0]   pending_amounts [$];
   change_type         expected_change [$];
   logic               taken = 1'b0;
   int                 sender_idle_pct = 0;
   int                 n_issued = 0;
   int                 n_checked = 0;
   int                 n_errors = 0;
   int                 cycle_count = 0;

   min_coin_change_dp i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_target_amount (req_target_amount),
      .rsp_valid         (rsp_valid),
      .rsp_min_count     (rsp_min_count),
      .rsp_reachable     (rsp_reachable),
      .rsp_tally_a       (rsp_tally_a),
      .rsp_tally_b       (rsp_tally_b),
      .rsp_tally_c       (rsp_tally_c),
      .rsp_tally_d       (rsp_tally_d),
      .rsp_tally_e       (rsp_tally_e),
      .rsp_tally_f       (rsp_tally_f),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // bottom-up fill of the count table, then a greedy walk down from the target
   // picking the coin whose remainder has the strictly smallest count
   function automatic change_type make_change(input logic [OUT_W-1:0] amount);
      change_type       res;
      int unsigned      active;
      int unsigned      rem;
      int unsigned      steps;
      int unsigned      pick;
      logic [CNT_W-1:0] best;
      res.min_count = '0;
      res.reachable = 1'b0;
      res.tally     = '0;
      // coin count above the maximum saturates
      active = (coin_count > DEF_MAX_COINS) ? DEF_MAX_COINS : coin_count;
      dp_counts[0] = '0;
      for (int unsigned a = 1; a <= amount; a++) begin
         best = UNREACH;
         for (int unsigned d = 0; d < active; d++) begin
            // a zero-valued coin never fits
            if (coin_value[d] != 0 && coin_value[d] <= a &&
                dp_counts[a - coin_value[d]] < best) begin
               best = dp_counts[a - coin_value[d]];
            end
         end
         dp_counts[a] = (best == UNREACH) ? UNREACH : best + 1'b1;
      end
      // unreachable amount: everything stays zero
      if (dp_counts[amount] == UNREACH) begin
         return res;
      end
      rem   = amount;
      steps = 0;
      while (rem > 0 && steps <= DEF_MAX_AMOUNT) begin
         best = UNREACH;
         pick = NUM_COIN_REGS;
         for (int unsigned d = 0; d < active; d++) begin
            // strict compare, so a tie keeps the lowest coin index
            if (coin_value[d] != 0 && coin_value[d] <= rem &&
                dp_counts[rem - coin_value[d]] < best) begin
               best = dp_counts[rem - coin_value[d]];
               pick = d;
            end
         end
         if (pick >= NUM_COIN_REGS) begin
            break;
         end
         res.tally[pick] = res.tally[pick] + 1'b1;
         rem   = rem - coin_value[pick];
         steps = steps + 1;
      end
      res.min_count = dp_counts[amount][OUT_W-1:0];
      res.reachable = 1'b1;
      return res;
   endfunction

   task automatic report_mismatch(input string field, input int want, input int got);
      n_errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // driver: presents the next pending amount at the falling edge once the slot is free
   always @(negedge clock) begin
      if (!reset && (!start || taken)) begin
         if (pending_amounts.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_target_amount <= pending_amounts.pop_front();
            start             <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: checks results against the oldest expectation, records accepted transactions
   always @(posedge clock) begin
      change_type want;
      change_type got;
      if (reset) begin
         taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            got.min_count = rsp_min_count;
            got.reachable = rsp_reachable;
            got.tally     = {rsp_tally_f, rsp_tally_e, rsp_tally_d,
                             rsp_tally_c, rsp_tally_b, rsp_tally_a};
            if (expected_change.size() == 0) begin
               n_errors++;
               $display("%0t ns: result with no transaction outstanding, %s %0d",
                        $time, "expected none, actual min_count", got.min_count);
            end else begin
               want = expected_change.pop_front();
               if (got.min_count !== want.min_count) begin
                  report_mismatch("min_count", want.min_count, got.min_count);
               end
               if (got.reachable !== want.reachable) begin
                  report_mismatch("reachable", want.reachable, got.reachable);
               end
               for (int i = 0; i < NUM_COIN_REGS; i++) begin
                  if (got.tally[i] !== want.tally[i]) begin
                     report_mismatch($sformatf("tally of coin %0d", i),
                                     want.tally[i], got.tally[i]);
                  end
               end
               n_checked++;
            end
         end
         // transaction accepted at this edge
         if (start && !busy) begin
            expected_change.insert(expected_change.size(), make_change(req_target_amount));
         end
         taken <= start && !busy;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[min_coin_change_dp] ERROR");
         $finish;
      end
   end

   // register write, kept in step with the predictor's copy
   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_NUM_COINS) begin
         coin_count = data[IDX_W-1:0];
      end else if (idx <= CSR_COIN_F) begin
         coin_value[idx - 1] = data[COIN_W-1:0];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_amount(input logic [OUT_W-1:0] amount);
      pending_amounts.insert(pending_amounts.size(), amount);
      n_issued++;
   endtask

   // sender holds off until every outstanding result has come back
   task automatic wait_drained();
      while (n_checked != n_issued) begin
         @(negedge clock);
      end
   endtask

   // mostly small coins so that most amounts are reachable, now and then zero or huge
   task automatic random_coins();
      int unsigned      roll;
      logic [CSR_W-1:0] value;
      // junk in the upper bits of the coin count write is dropped by the block
      csr_write(CSR_NUM_COINS, {7'($urandom), 3'($urandom_range(7, 1))});
      for (int i = 0; i < NUM_COIN_REGS; i++) begin
         roll = $urandom_range(15);
         if (roll == 0) begin
            value = '0;
         end else if (roll == 1) begin
            value = 10'($urandom_range(1023, 1));
         end else begin
            value = 10'($urandom_range(12, 1));
         end
         csr_write(IDX_W'(CSR_COIN_A + i), value);
      end
   endtask

   // mostly small targets keep the run short, a few span the whole range
   function automatic logic [OUT_W-1:0] random_amount();
      if ($urandom_range(15) == 0) begin
         return 10'($urandom_range(1023));
      end
      return 10'($urandom_range(63));
   endfunction

   initial begin
      int idle_by_phase [4];
      idle_by_phase = '{0, 76, 0, 34};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default coin set 1, 2, 3: zero target, small ones, all-ones and alternating bits
      queue_amount(10'd0);
      queue_amount(10'd1);
      queue_amount(10'd6);
      queue_amount(10'd1023);
      queue_amount(10'd682);
      queue_amount(10'd341);
      wait_drained();

      // no coins at all: only zero is reachable; upper write bits ignored
      csr_write(CSR_NUM_COINS, 10'h3f8);
      queue_amount(10'd0);
      queue_amount(10'd5);
      wait_drained();

      // coin count of seven saturates to six, a zero coin, a tie between a and f,
      // largest coin value; the write to the unused index must change nothing
      csr_write(CSR_NUM_COINS, 10'd7);
      csr_write(CSR_COIN_A, 10'd4);
      csr_write(CSR_COIN_B, 10'd0);
      csr_write(CSR_COIN_C, 10'd6);
      csr_write(CSR_COIN_D, 10'd9);
      csr_write(CSR_COIN_E, 10'd1023);
      csr_write(CSR_COIN_F, 10'd4);
      csr_write(CSR_IDX_UNUSED, 10'h3ff);
      queue_amount(10'd1);
      queue_amount(10'd3);
      queue_amount(10'd4);
      queue_amount(10'd8);
      queue_amount(10'd10);
      queue_amount(10'd12);
      queue_amount(10'd13);
      queue_amount(10'd24);
      queue_amount(10'd1023);
      wait_drained();

      // two coins active, the rest left set but inactive so their tallies stay zero
      csr_write(CSR_NUM_COINS, 10'd2);
      csr_write(CSR_COIN_A, 10'd1023);
      csr_write(CSR_COIN_B, 10'd1);
      queue_amount(10'd1023);
      queue_amount(10'd1022);
      wait_drained();

      // random phases: new coin set each time, sender gaps vary per phase
      // (the receiver cannot hold results off, so only sender idling applies)
      for (int p = 0; p < 4; p++) begin
         random_coins();
         sender_idle_pct = idle_by_phase[p];
         for (int k = 0; k < 20; k++) begin
            queue_amount(random_amount());
         end
         wait_drained();
         sender_idle_pct = 0;
      end

      // catch any stray late result
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (n_errors == 0 && expected_change.size() == 0) begin
         $display("[min_coin_change_dp] OK");
      end else begin
         $display("[min_coin_change_dp] ERROR");
      end
      $finish;
   end

endmodule
